>>> sv/lds_pkg.sv
// ----------------------------------------------------------------------------
// lds_pkg
// Types, constants and schedule tables for the lamp dimming scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package lds_pkg;

  // window depth default
  localparam int LDS_WINDOW = 5;

  // field widths
  localparam int LIGHT_W = 10;
  localparam int DUTY_W  = 7;
  localparam int STAGE_W = 3;
  localparam int MODE_W  = 3;
  localparam int SEC_W   = 12;
  localparam int HOUR_W  = 16;

  // apb port
  localparam int APB_DW = 32;
  localparam int APB_AW = 4;

  // register indexes
  localparam logic [1:0] REG_ON_THR  = 2'd0;
  localparam logic [1:0] REG_OFF_THR = 2'd1;
  localparam logic [1:0] REG_MODE    = 2'd2;
  localparam logic [1:0] REG_LEVEL   = 2'd3;

  // register reset values
  localparam logic [LIGHT_W-1:0] ON_THR_RST  = LIGHT_W'(600);
  localparam logic [LIGHT_W-1:0] OFF_THR_RST = LIGHT_W'(400);
  localparam logic [MODE_W-1:0]  MODE_RST    = '0;
  localparam logic [DUTY_W-1:0]  LEVEL_RST   = DUTY_W'(50);

  // request types
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  // schedule modes
  localparam logic [MODE_W-1:0] MODE_THREE_STEP = 3'd0;
  localparam logic [MODE_W-1:0] MODE_TWO_STEP_6 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_TWO_STEP_9 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_SECONDS    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_FIVE_STEP  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_TABLE_A    = 3'd5;
  localparam logic [MODE_W-1:0] MODE_TABLE_B    = 3'd6;

  // stages
  localparam logic [STAGE_W-1:0] STAGE_OFF = 3'd0;
  localparam logic [STAGE_W-1:0] STAGE_1   = 3'd1;
  localparam logic [STAGE_W-1:0] STAGE_2   = 3'd2;
  localparam logic [STAGE_W-1:0] STAGE_3   = 3'd3;
  localparam logic [STAGE_W-1:0] STAGE_4   = 3'd4;
  localparam logic [STAGE_W-1:0] STAGE_5   = 3'd5;

  // duty values
  localparam logic [DUTY_W-1:0] DUTY_OFF  = 7'd0;
  localparam logic [DUTY_W-1:0] DUTY_FULL = 7'd100;
  localparam logic [DUTY_W-1:0] DUTY_80   = 7'd80;
  localparam logic [DUTY_W-1:0] DUTY_75   = 7'd75;
  localparam logic [DUTY_W-1:0] DUTY_60   = 7'd60;
  localparam logic [DUTY_W-1:0] DUTY_50   = 7'd50;
  localparam logic [DUTY_W-1:0] DUTY_61   = 7'd61;
  localparam logic [DUTY_W-1:0] DUTY_43   = 7'd43;
  localparam logic [DUTY_W-1:0] DUTY_52   = 7'd52;

  // timer limits
  localparam logic [SEC_W-1:0] SEC_PER_HOUR = SEC_W'(3600);
  localparam logic [SEC_W-1:0] SEC_WRAP_30  = SEC_W'(30);

  // configuration register set
  typedef struct packed {
    logic [LIGHT_W-1:0] on_thr;
    logic [LIGHT_W-1:0] off_thr;
    logic [MODE_W-1:0]  mode;
    logic [DUTY_W-1:0]  level;
  } lds_cfg_t;

  // window status for the sample in flight
  typedef struct packed {
    logic full;
    logic fill_last;
    logic first_below_on;
    logic all_day;
    logic all_night;
  } lds_win_t;

  // one result beat
  typedef struct packed {
    logic               lamp_on;
    logic [DUTY_W-1:0]  duty_percent;
    logic [STAGE_W-1:0] dim_stage;
    logic               timer_running;
  } lds_res_t;

  // stage chosen by the schedule of a mode
  function automatic logic [STAGE_W-1:0] pick_stage(
    input logic [MODE_W-1:0]  mode,
    input logic [STAGE_W-1:0] cur,
    input logic [HOUR_W-1:0]  hr,
    input logic [SEC_W-1:0]   sec
  );
    logic [STAGE_W-1:0] st;
    st = cur;
    unique case (mode)
      MODE_THREE_STEP: st = (hr < 16'd6) ? STAGE_1 : ((hr < 16'd10) ? STAGE_2 : STAGE_3);
      MODE_TWO_STEP_6: st = (hr < 16'd6) ? STAGE_1 : STAGE_2;
      MODE_TWO_STEP_9: st = (hr < 16'd9) ? STAGE_1 : STAGE_2;
      MODE_SECONDS: begin
        if (sec < SEC_W'(10))      st = STAGE_1;
        else if (sec < SEC_W'(20)) st = STAGE_2;
        else if (sec < SEC_WRAP_30) st = STAGE_3;
        else                       st = STAGE_1;
      end
      MODE_FIVE_STEP: begin
        if (hr < 16'd1)       st = STAGE_1;
        else if (hr < 16'd4)  st = STAGE_2;
        else if (hr < 16'd5)  st = STAGE_3;
        else if (hr < 16'd12) st = STAGE_4;
        else                  st = STAGE_5;
      end
      MODE_TABLE_A: begin
        if (hr < 16'd5)       st = STAGE_1;
        else if (hr < 16'd7)  st = STAGE_2;
        else if (hr < 16'd11) st = STAGE_3;
        else if (hr < 16'd12) st = STAGE_4;
        else                  st = STAGE_5;
      end
      MODE_TABLE_B: begin
        if (hr < 16'd4)       st = STAGE_1;
        else if (hr < 16'd7)  st = STAGE_2;
        else if (hr < 16'd11) st = STAGE_3;
        else                  st = STAGE_4;
      end
      default: st = cur;
    endcase
    return st;
  endfunction

  // duty for a stage; stages without an entry keep the current duty
  function automatic logic [DUTY_W-1:0] duty_for_stage(
    input logic [MODE_W-1:0]  mode,
    input logic [STAGE_W-1:0] st,
    input logic [DUTY_W-1:0]  level,
    input logic [DUTY_W-1:0]  cur
  );
    logic [DUTY_W-1:0] d;
    d = cur;
    if (mode == MODE_TABLE_A) begin
      case (st)
        STAGE_OFF: d = DUTY_OFF;
        STAGE_1:   d = DUTY_FULL;
        STAGE_2:   d = DUTY_75;
        STAGE_3:   d = DUTY_50;
        STAGE_4, STAGE_5: d = DUTY_60;
        default:   d = cur;
      endcase
    end else if (mode == MODE_TABLE_B) begin
      case (st)
        STAGE_OFF: d = DUTY_OFF;
        STAGE_1:   d = DUTY_FULL;
        STAGE_2:   d = DUTY_61;
        STAGE_3:   d = DUTY_43;
        STAGE_4:   d = DUTY_52;
        default:   d = cur;
      endcase
    end else begin
      case (st)
        STAGE_OFF: d = DUTY_OFF;
        STAGE_1:   d = DUTY_FULL;
        STAGE_2:   d = (level > DUTY_FULL) ? DUTY_FULL : level;
        STAGE_3:   d = DUTY_80;
        default:   d = cur;
      endcase
    end
    return d;
  endfunction

endpackage

`default_nettype wire

>>> sv/lds_if.sv
// ----------------------------------------------------------------------------
// lds_if
// Valid/ready channels for request beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface lds_in_if
  import lds_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [LIGHT_W-1:0] light_sample;

  modport source (output valid, output req_type, output light_sample, input ready);
  modport sink   (input valid, input req_type, input light_sample, output ready);
endinterface

interface lds_out_if
  import lds_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               lamp_on;
  logic [DUTY_W-1:0]  duty_percent;
  logic [STAGE_W-1:0] dim_stage;
  logic               timer_running;

  modport source (output valid, output lamp_on, output duty_percent, output dim_stage,
                  output timer_running, input ready);
  modport sink   (input valid, input lamp_on, input duty_percent, input dim_stage,
                  input timer_running, output ready);
endinterface

`default_nettype wire

>>> sv/lds_cfg_regs.sv
// ----------------------------------------------------------------------------
// lds_cfg_regs
// APB register file holding thresholds, schedule mode and dim level.
// ----------------------------------------------------------------------------
`default_nettype none

module lds_cfg_regs
  import lds_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output lds_cfg_t               cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.on_thr  <= ON_THR_RST;
      cfg.off_thr <= OFF_THR_RST;
      cfg.mode    <= MODE_RST;
      cfg.level   <= LEVEL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ON_THR:  cfg.on_thr  <= pwdata[LIGHT_W-1:0];
        REG_OFF_THR: cfg.off_thr <= pwdata[LIGHT_W-1:0];
        REG_MODE:    cfg.mode    <= pwdata[MODE_W-1:0];
        REG_LEVEL:   cfg.level   <= pwdata[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_ON_THR:  prdata = APB_DW'(cfg.on_thr);
      REG_OFF_THR: prdata = APB_DW'(cfg.off_thr);
      REG_MODE:    prdata = APB_DW'(cfg.mode);
      REG_LEVEL:   prdata = APB_DW'(cfg.level);
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

>>> sv/lds_window.sv
// ----------------------------------------------------------------------------
// lds_window
// Light sample window with fill tracking and parallel day/night compare.
// ----------------------------------------------------------------------------
`default_nettype none

module lds_window
  import lds_pkg::*;
#(
  parameter int WINDOW = LDS_WINDOW
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [LIGHT_W-1:0] sample,
  input  wire lds_cfg_t           cfg,
  output lds_win_t                status
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W  = $clog2(WINDOW + 1);

  logic [LIGHT_W-1:0] entry [WINDOW];
  logic [LIGHT_W-1:0] entry_new [WINDOW];
  logic [CNT_W-1:0]   fill_count;
  logic [SLOT_W-1:0]  write_slot;
  logic [SLOT_W-1:0]  wr_idx;
  logic               full;
  logic               day_all;
  logic               night_all;

  assign full   = (fill_count == CNT_W'(WINDOW));
  assign wr_idx = full ? write_slot : fill_count[SLOT_W-1:0];

  // window as it reads with the new sample in place
  always_comb begin
    for (int i = 0; i < WINDOW; i++) begin
      entry_new[i] = (wr_idx == SLOT_W'(i)) ? sample : entry[i];
    end
  end

  // all-day and all-night flags over every entry
  always_comb begin
    day_all   = 1'b1;
    night_all = 1'b1;
    for (int i = 0; i < WINDOW; i++) begin
      if (entry_new[i] < cfg.off_thr) begin
        night_all = 1'b0;
      end else begin
        day_all = 1'b0;
        if (!(entry_new[i] > cfg.on_thr)) night_all = 1'b0;
      end
    end
  end

  assign status.full           = full;
  assign status.fill_last      = !full && (fill_count == CNT_W'(WINDOW - 1));
  assign status.first_below_on = (entry_new[0] < cfg.on_thr);
  assign status.all_day        = day_all;
  assign status.all_night      = night_all;

  // entry storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < WINDOW; i++) begin
        if (wr_idx == SLOT_W'(i)) entry[i] <= sample;
      end
    end
  end

  // fill count and write slot
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      write_slot <= '0;
    end else if (wr_en) begin
      if (!full) begin
        fill_count <= fill_count + CNT_W'(1);
      end else if (write_slot == SLOT_W'(WINDOW - 1)) begin
        write_slot <= '0;
      end else begin
        write_slot <= write_slot + SLOT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/lds_ctrl.sv
// ----------------------------------------------------------------------------
// lds_ctrl
// Lamp state, schedule stage, duty and elapsed-time counters.
// ----------------------------------------------------------------------------
`default_nettype none

module lds_ctrl
  import lds_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  wire logic     req_type,
  input  wire lds_win_t win,
  input  wire lds_cfg_t cfg,
  output lds_res_t      res_next
);

  logic               lamp_state, lamp_state_next;
  logic [DUTY_W-1:0]  duty_reg, duty_reg_next;
  logic [STAGE_W-1:0] stage_now, stage_now_next;
  logic [STAGE_W-1:0] stage_before, stage_before_next;
  logic               counting, counting_next;
  logic [SEC_W-1:0]   seconds_count, seconds_count_next;
  logic [HOUR_W-1:0]  hours_count, hours_count_next;
  logic [SEC_W-1:0]   sec_inc;

  assign sec_inc = seconds_count + SEC_W'(1);

  // state update for one beat
  always_comb begin
    lamp_state_next    = lamp_state;
    duty_reg_next      = duty_reg;
    stage_now_next     = stage_now;
    stage_before_next  = stage_before;
    counting_next      = counting;
    seconds_count_next = seconds_count;
    hours_count_next   = hours_count;
    if (step) begin
      if (req_type == REQ_TICK) begin
        // tick only counts while the timer runs
        if (counting) begin
          if (sec_inc >= SEC_PER_HOUR) begin
            seconds_count_next = '0;
            hours_count_next   = hours_count + HOUR_W'(1);
          end else begin
            seconds_count_next = sec_inc;
          end
        end
      end else if (!win.full) begin
        // last fill sample sets the lamp from the first entry
        if (win.fill_last) begin
          lamp_state_next = !win.first_below_on;
          duty_reg_next   = win.first_below_on ? DUTY_OFF : DUTY_FULL;
        end
      end else begin
        if (win.all_day) begin
          if (lamp_state) begin
            lamp_state_next = 1'b0;
            duty_reg_next   = DUTY_OFF;
            counting_next   = 1'b0;
          end
          stage_now_next     = STAGE_OFF;
          stage_before_next  = STAGE_OFF;
          seconds_count_next = '0;
          hours_count_next   = '0;
        end else if (win.all_night) begin
          lamp_state_next = 1'b1;
          if (!counting) begin
            seconds_count_next = '0;
            hours_count_next   = '0;
            counting_next      = 1'b1;
          end
          if (stage_now == STAGE_OFF) duty_reg_next = DUTY_FULL;
        end
        // schedule
        if (lamp_state_next) begin
          stage_now_next = pick_stage(cfg.mode, stage_now_next, hours_count_next,
                                      seconds_count_next);
          if (cfg.mode == MODE_SECONDS && seconds_count_next >= SEC_WRAP_30) begin
            seconds_count_next = '0;
          end
        end
        if (stage_before_next != stage_now_next) begin
          duty_reg_next = duty_for_stage(cfg.mode, stage_now_next, cfg.level, duty_reg_next);
        end
        stage_before_next = stage_now_next;
      end
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_state    <= 1'b0;
      duty_reg      <= DUTY_OFF;
      stage_now     <= STAGE_OFF;
      stage_before  <= STAGE_OFF;
      counting      <= 1'b0;
      seconds_count <= '0;
      hours_count   <= '0;
    end else begin
      lamp_state    <= lamp_state_next;
      duty_reg      <= duty_reg_next;
      stage_now     <= stage_now_next;
      stage_before  <= stage_before_next;
      counting      <= counting_next;
      seconds_count <= seconds_count_next;
      hours_count   <= hours_count_next;
    end
  end

  assign res_next.lamp_on       = lamp_state_next;
  assign res_next.duty_percent  = duty_reg_next;
  assign res_next.dim_stage     = stage_now_next;
  assign res_next.timer_running = counting_next;

endmodule

`default_nettype wire

>>> sv/lamp_dimming_scheduler_core.sv
// ----------------------------------------------------------------------------
// lamp_dimming_scheduler_core
// Night-light dimmer: sample window, lamp switching and dimming schedule.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        beat contents
//  in_ch     in   valid / ready    req_type, light_sample
//  out_ch    out  valid / ready    lamp_on, duty_percent, dim_stage, timer_running
//  apb       in   psel / penable   paddr, pwdata, prdata (pready tied high)
//
//  one beat per cycle sustained while out_ch.ready stays high; a result passes
//  through the input register, then the result register; the state update is the
//  only loop.
//  reset is synchronous: control state and registers return to defaults, window
//  contents are not cleared.
//  a stalled result holds in the result register while one more request waits
//  in the input register.
// ----------------------------------------------------------------------------
`default_nettype none

module lamp_dimming_scheduler_core
  import lds_pkg::*;
#(
  parameter int WINDOW = LDS_WINDOW
) (
  input  wire logic              clk,
  input  wire logic              rst,
  lds_in_if.sink                 in_ch,
  lds_out_if.source              out_ch,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready
);

  lds_cfg_t           cfg;
  lds_win_t           win;
  lds_res_t           res_next;
  lds_res_t           res;
  logic               in_vld;
  logic               in_type;
  logic [LIGHT_W-1:0] in_sample;
  logic               out_vld;
  logic               advance;
  logic               step;

  // pipeline control
  assign advance     = !out_vld || out_ch.ready;
  assign step        = in_vld && advance;
  assign in_ch.ready = !in_vld || advance;

  lds_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lds_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (step && (in_type == REQ_SAMPLE)),
    .sample (in_sample),
    .cfg    (cfg),
    .status (win)
  );

  lds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .req_type (in_type),
    .win      (win),
    .cfg      (cfg),
    .res_next (res_next)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      in_vld <= 1'b1;
    end else if (step) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_type   <= in_ch.req_type;
      in_sample <= in_ch.light_sample;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (step) begin
      out_vld <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res <= res_next;
  end

  assign out_ch.valid         = out_vld;
  assign out_ch.lamp_on       = res.lamp_on;
  assign out_ch.duty_percent  = res.duty_percent;
  assign out_ch.dim_stage     = res.dim_stage;
  assign out_ch.timer_running = res.timer_running;

`ifndef SYNTHESIS
  // a nonzero stage only while the lamp is on
  a_stage_needs_lamp: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.dim_stage == STAGE_OFF || out_ch.lamp_on))
    else $error("dim stage set while lamp off");

  // timer runs only with the lamp on
  a_timer_needs_lamp: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.timer_running |-> out_ch.lamp_on)
    else $error("timer running while lamp off");

  // duty never above full scale
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.duty_percent <= DUTY_FULL)
    else $error("duty above 100 percent");

  // a held request is neither dropped nor overwritten while the result stalls
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_vld && !advance |=> in_vld && $stable(in_sample) && $stable(in_type))
    else $error("held request lost during stall");
`endif

endmodule

`default_nettype wire
